// ===== rtl/core/smpd_pkg.sv =====
// Shared types and constants for the sync marker packet deframer.
// Used by smpd_front, smpd_queue, smpd_back and sync_marker_packet_deframer.
package smpd_pkg;

	// Header window
	localparam int unsigned WIN_LEN    = 10;
	localparam int unsigned FILL_W     = 4;
	localparam int unsigned SKIP_W     = 17;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned PKT_NUM_W  = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_VALUE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLAGS_VALUE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_VALUE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_APID  = 3'd4;

	// Register reset values
	localparam logic [31:0] SYNC_WORD_RST      = 32'h352E_F853;
	localparam logic [7:0]  TYPE_VALUE_RST     = 8'h0A;
	localparam logic [7:0]  FLAGS_VALUE_RST    = 8'hC0;
	localparam logic [7:0]  SEQUENCE_VALUE_RST = 8'h01;
	localparam logic [7:0]  EXCLUDED_APID_RST  = 8'h22;

	// Result queue depth default
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Stream widths
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 40;

	typedef struct packed {
		logic [BYTE_W-1:0]    apid;
		logic [LEN_W-1:0]     pkt_len;
		logic                 is_excluded;
		logic [PKT_NUM_W-1:0] packet_number;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t data;
	} push_t;

endpackage

// ===== rtl/core/smpd_front.sv =====
// Front part: accepts stream bytes, keeps the header window, tests candidates
// and pushes matches into the result queue. Holds the configuration registers.
// Depends on smpd_pkg.
module smpd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [smpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [smpd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [smpd_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic                               queue_full,
	output smpd_pkg::push_t                    push
);

	logic [31:0] sync_word_q;
	logic [7:0]  type_value_q;
	logic [7:0]  flags_value_q;
	logic [7:0]  sequence_value_q;
	logic [7:0]  excluded_apid_q;

	logic [smpd_pkg::BYTE_W-1:0]    window_q [smpd_pkg::WIN_LEN];
	logic [smpd_pkg::BYTE_W-1:0]    window_nxt [smpd_pkg::WIN_LEN];
	logic [smpd_pkg::FILL_W-1:0]    fill_q;
	logic [smpd_pkg::SKIP_W-1:0]    skip_q;
	logic [smpd_pkg::PKT_NUM_W-1:0] found_q;

	logic                           accept;
	logic                           full_window;
	logic                           header_ok;
	logic                           match;
	logic [smpd_pkg::LEN_W-1:0]     len;
	logic [31:0]                    marker;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q      <= smpd_pkg::SYNC_WORD_RST;
			type_value_q     <= smpd_pkg::TYPE_VALUE_RST;
			flags_value_q    <= smpd_pkg::FLAGS_VALUE_RST;
			sequence_value_q <= smpd_pkg::SEQUENCE_VALUE_RST;
			excluded_apid_q  <= smpd_pkg::EXCLUDED_APID_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				smpd_pkg::REG_SYNC_WORD:      sync_word_q      <= cfg_data;
				smpd_pkg::REG_TYPE_VALUE:     type_value_q     <= cfg_data[7:0];
				smpd_pkg::REG_FLAGS_VALUE:    flags_value_q    <= cfg_data[7:0];
				smpd_pkg::REG_SEQUENCE_VALUE: sequence_value_q <= cfg_data[7:0];
				smpd_pkg::REG_EXCLUDED_APID:  excluded_apid_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Accept while the queue can take a result
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	// Shift the new byte in at the young end
	always_comb begin
		for (int i = 0; i < smpd_pkg::WIN_LEN - 1; i++) begin
			window_nxt[i] = window_q[i+1];
		end
		window_nxt[smpd_pkg::WIN_LEN-1] = s_tdata;
	end

	// Test the candidate at the oldest byte of the shifted window
	assign full_window = (fill_q >= smpd_pkg::FILL_W'(smpd_pkg::WIN_LEN - 1));
	assign marker      = {window_nxt[0], window_nxt[1], window_nxt[2], window_nxt[3]};
	assign header_ok   = (marker == sync_word_q) &&
	                     (window_nxt[4] == type_value_q) &&
	                     (window_nxt[6] == flags_value_q) &&
	                     (window_nxt[7] == sequence_value_q);
	assign match       = accept && full_window && (skip_q == '0) && header_ok;
	assign len         = {window_nxt[8], window_nxt[9]};

	// Window, fill, skip and packet count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < smpd_pkg::WIN_LEN; i++) begin
				window_q[i] <= '0;
			end
			fill_q  <= '0;
			skip_q  <= '0;
			found_q <= '0;
		end else if (accept) begin
			window_q <= window_nxt;
			if (!full_window) begin
				fill_q <= fill_q + 1'b1;
			end
			if (full_window) begin
				if (skip_q != '0) begin
					skip_q <= skip_q - 1'b1;
				end else if (header_ok) begin
					skip_q <= smpd_pkg::SKIP_W'(len) + smpd_pkg::SKIP_W'(3);
					if (found_q != '1) begin
						found_q <= found_q + 1'b1;
					end
				end
			end
		end
	end

	// Build the result for the queue
	always_comb begin
		push.push               = match;
		push.data.apid          = window_nxt[5];
		push.data.pkt_len       = len;
		push.data.is_excluded   = (window_nxt[5] == excluded_apid_q);
		push.data.packet_number = found_q;
	end

endmodule

// ===== rtl/core/smpd_queue.sv =====
// Short result queue between the front and back parts.
// Depends on smpd_pkg.
module smpd_queue #(
	parameter int unsigned DEPTH = smpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  smpd_pkg::push_t   push,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output smpd_pkg::result_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	smpd_pkg::result_t  entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push.push && !full;
	assign do_pop    = pop && not_empty;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/smpd_back.sv =====
// Back part: output register that takes results from the queue and
// presents them on the master stream. Depends on smpd_pkg.
module smpd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_not_empty,
	input  smpd_pkg::result_t              q_head,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [smpd_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tuser
);

	logic              out_valid_q;
	smpd_pkg::result_t out_q;

	// Load when the register is empty or being taken
	assign q_pop = q_not_empty && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= q_head;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.packet_number, out_q.pkt_len, out_q.apid};
	assign m_tuser  = out_q.is_excluded;

endmodule

// ===== rtl/core/sync_marker_packet_deframer.sv =====
// Sync marker packet deframer, top level.
// Throughput: one byte per cycle; s_tready drops only while the result queue is
// full behind a stalled receiver. A matching header's result is written into the
// queue when its last byte is accepted, then loaded into the output register that
// drives m_tvalid. Reset clears window fill, skip count, packet counter, queue and
// output register, and loads the register defaults.
module sync_marker_packet_deframer #(
	parameter int unsigned QUEUE_DEPTH = smpd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes
	input  logic                            cfg_wen,
	input  logic [smpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smpd_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input bytes
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [smpd_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
	// Results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] apid, [23:8] pkt_len, [39:24] packet_number
	output logic [smpd_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                            m_tuser    // [0] is_excluded
);

	smpd_pkg::push_t   push;
	smpd_pkg::result_t q_head;
	logic              q_full;
	logic              q_not_empty;
	logic              q_pop;

	smpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (q_full),
		.push       (push)
	);

	smpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	smpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

// ===== bench/tb_sync_marker_packet_deframer.sv =====
// Testbench for sync_marker_packet_deframer: directed bytes, then random framed
// streams under several register settings and idling patterns.
// Depends on smpd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_sync_marker_packet_deframer;

	localparam int          HALF_PERIOD   = 4;
	localparam int          QUIET_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES  = 6;
	localparam int          MAX_REPORTS   = 100;
	localparam int          PHASE_BYTES   = 70;
	localparam int          NUM_PHASES    = 8;
	localparam logic [smpd_pkg::CFG_IDX_W-1:0] REG_LAST_INDEX = {smpd_pkg::CFG_IDX_W{1'b1}};

	typedef struct packed {
		logic [7:0]        data;
		logic              has_want;
		smpd_pkg::result_t want;
	} byte_row_t;

	// Two back-to-back headers under the reset settings, then skipped bytes
	localparam byte_row_t DIRECTED_ROWS [25] = '{
		'{8'h35, 1'b0, '0}, '{8'h2E, 1'b0, '0}, '{8'hF8, 1'b0, '0},
		'{8'h53, 1'b0, '0}, '{8'h0A, 1'b0, '0}, '{8'h22, 1'b0, '0},
		'{8'hC0, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{8'h22, 16'h0000, 1'b1, 16'd0}},
		'{8'h35, 1'b0, '0}, '{8'h2E, 1'b0, '0}, '{8'hF8, 1'b0, '0},
		'{8'h53, 1'b0, '0}, '{8'h0A, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'hC0, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h05, 1'b1, '{8'h00, 16'h0005, 1'b0, 16'd1}},
		'{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [smpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [smpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [smpd_pkg::S_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [smpd_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                            m_tuser;

	sync_marker_packet_deframer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] data_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] apid, [23:8] pkt_len, [39:24] packet_number
		.m_tuser  (m_tuser)    // [0] is_excluded
	);

	// Shadow of the register file
	logic [31:0] cur_sync;
	logic [7:0]  cur_type;
	logic [7:0]  cur_flags;
	logic [7:0]  cur_seq;
	logic [7:0]  cur_excl;

	// Shadow of the header window and counters
	logic [7:0]  win_bytes [smpd_pkg::WIN_LEN];
	logic [3:0]  win_fill;
	logic [16:0] skip_left;
	logic [15:0] found_count;

	smpd_pkg::result_t pending_packets [$];
	int      src_gap_pct = 0;
	int      snk_stall_pct = 0;
	int      mismatch_count = 0;
	int      quiet_cycles = 0;

	always #HALF_PERIOD clk = ~clk;

	// Shift one byte into the window and test the oldest candidate start
	function automatic logic deframe_byte(input logic [7:0] b,
	                                      output smpd_pkg::result_t pkt);
		logic [15:0] len;
		pkt = '0;
		for (int i = 0; i < smpd_pkg::WIN_LEN - 1; i++)
			win_bytes[i] = win_bytes[i + 1];
		win_bytes[smpd_pkg::WIN_LEN - 1] = b;
		if (win_fill < smpd_pkg::WIN_LEN) begin
			win_fill++;
			if (win_fill < smpd_pkg::WIN_LEN)
				return 1'b0;
		end
		if (skip_left != 0) begin
			skip_left--;
			return 1'b0;
		end
		if ({win_bytes[0], win_bytes[1], win_bytes[2], win_bytes[3]} != cur_sync ||
		    win_bytes[4] != cur_type || win_bytes[6] != cur_flags ||
		    win_bytes[7] != cur_seq)
			return 1'b0;
		len = {win_bytes[8], win_bytes[9]};
		pkt.apid          = win_bytes[5];
		pkt.pkt_len       = len;
		pkt.is_excluded   = (win_bytes[5] == cur_excl);
		pkt.packet_number = found_count;
		skip_left = {1'b0, len} + 17'd3;
		if (found_count != 16'hFFFF)
			found_count++;
		return 1'b1;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input logic has_want,
	                         input smpd_pkg::result_t want);
		smpd_pkg::result_t pkt;
		logic    hit;
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		hit = deframe_byte(b, pkt);
		if (has_want)
			pending_packets.push_back(want);
		else if (hit)
			pending_packets.push_back(pkt);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [smpd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			smpd_pkg::REG_SYNC_WORD:      cur_sync  = val;
			smpd_pkg::REG_TYPE_VALUE:     cur_type  = val[7:0];
			smpd_pkg::REG_FLAGS_VALUE:    cur_flags = val[7:0];
			smpd_pkg::REG_SEQUENCE_VALUE: cur_seq   = val[7:0];
			smpd_pkg::REG_EXCLUDED_APID:  cur_excl  = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Write all registers plus one index beyond the list, which must be ignored
	task automatic set_config(input logic [31:0] sync, input logic [7:0] typ,
	                          input logic [7:0] flags, input logic [7:0] seq,
	                          input logic [7:0] excl);
		write_reg(smpd_pkg::REG_SYNC_WORD, sync);
		write_reg(smpd_pkg::REG_TYPE_VALUE, {24'h0, typ} | ($urandom & 32'hFFFF_FF00));
		write_reg(smpd_pkg::REG_FLAGS_VALUE, {24'h0, flags});
		write_reg(smpd_pkg::REG_SEQUENCE_VALUE, {24'h0, seq});
		write_reg(smpd_pkg::CFG_IDX_W'($urandom_range(int'(smpd_pkg::REG_EXCLUDED_APID) + 1,
		                                              int'(REG_LAST_INDEX))), $urandom);
		write_reg(smpd_pkg::REG_EXCLUDED_APID, {24'h0, excl});
		cfg_wen <= 1'b0;
	endtask

	// Hold off until every expected packet is out, then let the pipeline settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_packets.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed packets with random content, plus broken headers and noise
	task automatic send_random_stream(input int n_bytes);
		logic [7:0] hdr [smpd_pkg::WIN_LEN];
		int         sent;
		int         kind;
		int         len;
		int         idx;
		sent = 0;
		while (sent < n_bytes) begin
			kind = $urandom_range(9);
			if (kind <= 7) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
				{hdr[0], hdr[1], hdr[2], hdr[3]} = cur_sync;
				hdr[4] = cur_type;
				hdr[5] = ($urandom_range(3) == 0) ? cur_excl : 8'($urandom_range(255));
				hdr[6] = cur_flags;
				hdr[7] = cur_seq;
				{hdr[8], hdr[9]} = 16'(len);
				// Corrupt one compared byte so the header must be rejected
				if (kind >= 6) begin
					idx = $urandom_range(6);
					if (idx == 5)
						idx = 7;
					hdr[idx][$urandom_range(7)] ^= 1'b1;
				end
				for (int i = 0; i < smpd_pkg::WIN_LEN; i++)
					send_byte(hdr[i], 1'b0, '0);
				sent += smpd_pkg::WIN_LEN;
				for (int i = smpd_pkg::WIN_LEN - 4; i < len; i++) begin
					send_byte(8'($urandom_range(255)), 1'b0, '0);
					sent++;
				end
			end else begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(255)), 1'b0, '0);
				sent += len;
			end
		end
	endtask

	task automatic note_mismatch(input string field, input longint unsigned want,
	                             input longint unsigned got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
	endtask

	// Receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Check each accepted packet against the oldest expectation
	always @(posedge clk) begin : check_packets
		smpd_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_packets.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$error("packet with no expectation: tdata 0x%0h", m_tdata);
			end else begin
				want = pending_packets.pop_front();
				if (m_tdata[7:0] != want.apid)
					note_mismatch("apid", want.apid, m_tdata[7:0]);
				if (m_tdata[23:8] != want.pkt_len)
					note_mismatch("pkt_len", want.pkt_len, m_tdata[23:8]);
				if (m_tuser != want.is_excluded)
					note_mismatch("is_excluded", want.is_excluded, m_tuser);
				if (m_tdata[39:24] != want.packet_number)
					note_mismatch("packet_number", want.packet_number, m_tdata[39:24]);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sync_marker_packet_deframer: mismatch");
			$finish;
		end
	end

	initial begin
		cur_sync    = smpd_pkg::SYNC_WORD_RST;
		cur_type    = smpd_pkg::TYPE_VALUE_RST;
		cur_flags   = smpd_pkg::FLAGS_VALUE_RST;
		cur_seq     = smpd_pkg::SEQUENCE_VALUE_RST;
		cur_excl    = smpd_pkg::EXCLUDED_APID_RST;
		win_bytes   = '{default: 8'h00};
		win_fill    = '0;
		skip_left   = '0;
		found_count = '0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows under reset settings
		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);
		wait_drained();

		// Random phases: rotate register settings and idling patterns
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: ;
				2: set_config(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				3: set_config(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
				5: set_config(smpd_pkg::SYNC_WORD_RST, smpd_pkg::TYPE_VALUE_RST,
				              smpd_pkg::FLAGS_VALUE_RST, smpd_pkg::SEQUENCE_VALUE_RST,
				              smpd_pkg::EXCLUDED_APID_RST);
				default: set_config($urandom, 8'($urandom_range(255)), 8'($urandom_range(255)),
				                    8'($urandom_range(255)), 8'($urandom_range(255)));
			endcase
			case (phase % 4)
				0: begin src_gap_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_gap_pct = 87; snk_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  snk_stall_pct = 87; end
				default: begin src_gap_pct = 32; snk_stall_pct = 32; end
			endcase
			send_random_stream(PHASE_BYTES);
			wait_drained();
		end

		if (pending_packets.size() != 0) begin
			mismatch_count++;
			$error("%0d expected packets never arrived", pending_packets.size());
		end
		if (mismatch_count == 0)
			$display("sync_marker_packet_deframer: match");
		else
			$display("sync_marker_packet_deframer: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/smpd_pkg.sv
rtl/core/smpd_front.sv
rtl/core/smpd_queue.sv
rtl/core/smpd_back.sv
rtl/core/sync_marker_packet_deframer.sv
bench/tb_sync_marker_packet_deframer.sv
